// ===== sv/glow_splat_frame_engine_defines.svh =====
// assertion macros for the glow splat frame engine
// no dependencies; included by files that carry concurrent checks
`ifndef GLOW_SPLAT_FRAME_ENGINE_DEFINES_SVH
`define GLOW_SPLAT_FRAME_ENGINE_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define GSFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsfe check failed");

// next-cycle implication under synchronous active-low reset
`define GSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsfe check failed");

`endif

// ===== sv/gsfe_pkg.sv =====
// shared types, codes, constants and exp tables of the glow splat frame engine
// no dependencies
package gsfe_pkg;

    localparam int DEF_MAX_WIDTH        = 128;
    localparam int DEF_MAX_HEIGHT       = 128;
    localparam int DEF_SPLAT_RADIUS     = 6;
    localparam int DEF_MAX_STAMP_RADIUS = 15;

    localparam logic [7:0]  RST_FRAME_WIDTH  = 8'd100;
    localparam logic [7:0]  RST_FRAME_HEIGHT = 8'd100;
    localparam logic [3:0]  RST_STAMP_RADIUS = 4'd7;
    localparam logic [15:0] RST_GLOW_INV     = 16'd256;
    localparam logic [11:0] RST_COLOR        = 12'd256;

    // register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STAMP_RADIUS = 3'd2;
    localparam logic [2:0] REG_GLOW_INV     = 3'd3;
    localparam logic [2:0] REG_COLOR_RED    = 3'd4;
    localparam logic [2:0] REG_COLOR_GREEN  = 3'd5;
    localparam logic [2:0] REG_COLOR_BLUE   = 3'd6;

    // action codes
    localparam logic [1:0] ACT_SPLAT = 2'd0;
    localparam logic [1:0] ACT_STAMP = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam int CRD_W   = 13;  // window coordinate, signed
    localparam int CTR_W   = 12;  // truncated centre, signed
    localparam int OFF_W   = 6;   // window offset, signed
    localparam int T_W     = 22;  // exp argument, Q.8
    localparam int SQ_IN_W = 28;  // sqrt radicand
    localparam int SQ_RT_W = 14;  // sqrt root
    localparam int E_W     = 17;  // Q0.16 weight, 1.0 included
    localparam logic [E_W-1:0] GLOW_MIN_E = 17'd257;  // 255*e below 65536

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PIX, ST_SQRT, ST_TSCALE, ST_EXP1, ST_EXP2,
        ST_SCALE, ST_RD, ST_WR, ST_PRD, ST_COLOR, ST_DONE
    } state_t;

    function automatic logic [E_W-1:0] exp_int(input logic [3:0] n);
        logic [E_W-1:0] v;
        case (n)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd24109;
            4'd2:  v = 17'd8869;
            4'd3:  v = 17'd3263;
            4'd4:  v = 17'd1200;
            4'd5:  v = 17'd442;
            4'd6:  v = 17'd162;
            4'd7:  v = 17'd60;
            4'd8:  v = 17'd22;
            4'd9:  v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [E_W-1:0] exp_hi(input logic [3:0] h);
        logic [E_W-1:0] v;
        case (h)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32954;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [E_W-1:0] exp_lo(input logic [3:0] l);
        logic [E_W-1:0] v;
        case (l)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65280;
            4'd2:  v = 17'd65026;
            4'd3:  v = 17'd64772;
            4'd4:  v = 17'd64520;
            4'd5:  v = 17'd64268;
            4'd6:  v = 17'd64018;
            4'd7:  v = 17'd63768;
            4'd8:  v = 17'd63520;
            4'd9:  v = 17'd63272;
            4'd10: v = 17'd63025;
            4'd11: v = 17'd62780;
            4'd12: v = 17'd62535;
            4'd13: v = 17'd62291;
            4'd14: v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/glow_splat_frame_engine.sv =====
// glow splat frame engine: frame store with gaussian splat, glow stamp, read and clear
// depends on gsfe_pkg and glow_splat_frame_engine_defines.svh
// splat: ST_PIX, ST_EXP1, ST_EXP2, ST_SCALE, ST_RD, ST_WR per in-frame window pixel,
// ST_PIX per skipped one; stamp adds ST_SQRT (bit-serial square root) and ST_TSCALE,
// ending a too-faint pixel at ST_SCALE; read: ST_PIX, ST_PRD, ST_COLOR (ST_PIX off the
// frame); clear: one ST_CLEAR pass; all end in ST_DONE. one item at a time, result in
// an output register. reset: synchronous active low; then a clearing pass over all
// MAX_WIDTH*MAX_HEIGHT words (16384 at defaults) zeroes the store before s_tready rises
`include "glow_splat_frame_engine_defines.svh"

module glow_splat_frame_engine #(
    parameter int MAX_WIDTH        = gsfe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = gsfe_pkg::DEF_MAX_HEIGHT,
    parameter int SPLAT_RADIUS     = gsfe_pkg::DEF_SPLAT_RADIUS,
    parameter int MAX_STAMP_RADIUS = gsfe_pkg::DEF_MAX_STAMP_RADIUS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, splat_intensity
    input  logic [1:0]  s_tuser,   // action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red, green, blue
    output logic        m_tuser,   // pixel_valid
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CRD_W = gsfe_pkg::CRD_W;
    localparam int CTR_W = gsfe_pkg::CTR_W;
    localparam int OFF_W = gsfe_pkg::OFF_W;
    localparam int T_W   = gsfe_pkg::T_W;
    localparam int E_W   = gsfe_pkg::E_W;
    localparam int SQI_W = gsfe_pkg::SQ_IN_W;
    localparam int SQR_W = gsfe_pkg::SQ_RT_W;

    // ---------------- configuration registers ----------------
    logic [7:0]  frame_width_reg, frame_height_reg;
    logic [3:0]  stamp_radius_reg;
    logic [15:0] glow_inv_reg;
    logic [11:0] color_red_reg, color_green_reg, color_blue_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= gsfe_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= gsfe_pkg::RST_FRAME_HEIGHT;
            stamp_radius_reg <= gsfe_pkg::RST_STAMP_RADIUS;
            glow_inv_reg     <= gsfe_pkg::RST_GLOW_INV;
            color_red_reg    <= gsfe_pkg::RST_COLOR;
            color_green_reg  <= gsfe_pkg::RST_COLOR;
            color_blue_reg   <= gsfe_pkg::RST_COLOR;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                gsfe_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[7:0];
                gsfe_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[7:0];
                gsfe_pkg::REG_STAMP_RADIUS: stamp_radius_reg <= pwdata[3:0];
                gsfe_pkg::REG_GLOW_INV:     glow_inv_reg     <= pwdata[15:0];
                gsfe_pkg::REG_COLOR_RED:    color_red_reg    <= pwdata[11:0];
                gsfe_pkg::REG_COLOR_GREEN:  color_green_reg  <= pwdata[11:0];
                gsfe_pkg::REG_COLOR_BLUE:   color_blue_reg   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gsfe_pkg::REG_FRAME_WIDTH:  prdata = {24'd0, frame_width_reg};
            gsfe_pkg::REG_FRAME_HEIGHT: prdata = {24'd0, frame_height_reg};
            gsfe_pkg::REG_STAMP_RADIUS: prdata = {28'd0, stamp_radius_reg};
            gsfe_pkg::REG_GLOW_INV:     prdata = {16'd0, glow_inv_reg};
            gsfe_pkg::REG_COLOR_RED:    prdata = {20'd0, color_red_reg};
            gsfe_pkg::REG_COLOR_GREEN:  prdata = {20'd0, color_green_reg};
            gsfe_pkg::REG_COLOR_BLUE:   prdata = {20'd0, color_blue_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- frame memory: one port, registered read ----------------
    logic [15:0]   mem [DEPTH];
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // ---------------- sequencer state ----------------
    gsfe_pkg::state_t state_reg, state_next;

    logic [AW-1:0]             clr_addr_reg, clr_addr_next;
    logic                      clr_item_reg, clr_item_next;
    logic [1:0]                act_reg, act_next;
    logic signed [CTR_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [OFF_W-1:0]   fx_reg, fx_next, fy_reg, fy_next;   // sub-pixel part
    logic [15:0]               inten_reg, inten_next;
    logic [OFF_W-2:0]          rad_reg, rad_next;                  // window half width
    logic signed [OFF_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;   // window offsets
    logic [AW-1:0]             addr_reg, addr_next;
    logic [T_W-1:0]            t_reg, t_next;
    logic [SQI_W-1:0]          sq_rad_reg, sq_rad_next;
    logic [SQR_W+3:0]          sq_rem_reg, sq_rem_next;
    logic [SQR_W-1:0]          sq_root_reg, sq_root_next;
    logic [3:0]                sq_cnt_reg, sq_cnt_next;
    logic                      ezero_reg, ezero_next;
    logic [E_W-1:0]            r1_reg, r1_next, e_reg, e_next;
    logic [E_W-1:0]            val_reg, val_next;
    logic [27:0]               prod_r_reg, prod_r_next;
    logic [27:0]               prod_g_reg, prod_g_next;
    logic [27:0]               prod_b_reg, prod_b_next;
    logic                      pv_reg, pv_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [23:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg, m_tuser_next;

    assign s_tready = (state_reg == gsfe_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // saturated color byte from gain*pixel: (p*255) >> 20
    function automatic logic [7:0] color_byte(input logic [27:0] p);
        logic [35:0] q;
        q = {p, 8'd0} - {8'd0, p};
        return (|q[35:28]) ? 8'hFF : q[27:20];
    endfunction

    always_comb begin
        logic signed [16:0]      px, py, pxr, pyr;
        logic signed [16:0]      cxw, cyw;
        logic signed [CRD_W-1:0] x, y, w_used, h_used;
        logic                    in_frame, last_pix;
        logic signed [9:0]       dx, dy;
        logic [8:0]              ax, ay;
        logic [18:0]             d2s;
        logic [4:0]              sax, say;
        logic [10:0]             d2g;
        logic [SQR_W+3:0]        rem_sh, trial;
        logic [29:0]             st;
        logic [33:0]             p1, p2, pa;
        logic [17:0]             sum;
        logic [4:0]              stamp_r;
        logic [OFF_W-1:0]        rad_ext;

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        act_next      = act_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        inten_next    = inten_reg;
        rad_next      = rad_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        addr_next     = addr_reg;
        t_next        = t_reg;
        sq_rad_next   = sq_rad_reg;
        sq_rem_next   = sq_rem_reg;
        sq_root_next  = sq_root_reg;
        sq_cnt_next   = sq_cnt_reg;
        ezero_next    = ezero_reg;
        r1_next       = r1_reg;
        e_next        = e_reg;
        val_next      = val_reg;
        prod_r_next   = prod_r_reg;
        prod_g_next   = prod_g_reg;
        prod_b_next   = prod_b_reg;
        pv_next       = pv_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_wdata     = 16'd0;
        mem_addr      = addr_reg;

        // output register empties when taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // centre truncated toward zero, remainder kept for the splat distance
        px  = {s_tdata[15], s_tdata[15:0]};
        py  = {s_tdata[31], s_tdata[31:16]};
        pxr = px + (s_tdata[15] ? 17'sd15 : 17'sd0);
        pyr = py + (s_tdata[31] ? 17'sd15 : 17'sd0);
        cxw = pxr >>> 4;
        cyw = pyr >>> 4;

        // current window pixel and its frame test
        x = CRD_W'(cx_reg) + CRD_W'(ox_reg);
        y = CRD_W'(cy_reg) + CRD_W'(oy_reg);
        w_used = ({5'd0, frame_width_reg} > CRD_W'(MAX_WIDTH))
               ? CRD_W'(MAX_WIDTH) : {5'd0, frame_width_reg};
        h_used = ({5'd0, frame_height_reg} > CRD_W'(MAX_HEIGHT))
               ? CRD_W'(MAX_HEIGHT) : {5'd0, frame_height_reg};
        in_frame = !x[CRD_W-1] && !y[CRD_W-1] && (x < w_used) && (y < h_used);
        rad_ext  = {1'b0, rad_reg};
        last_pix = (ox_reg == $signed(rad_ext)) && (oy_reg == $signed(rad_ext));

        // splat distance in 1/16 pixel
        dx  = ($signed(10'(ox_reg)) <<< 4) - 10'(fx_reg);
        dy  = ($signed(10'(oy_reg)) <<< 4) - 10'(fy_reg);
        ax  = dx[9] ? 9'(-dx) : dx[8:0];
        ay  = dy[9] ? 9'(-dy) : dy[8:0];
        d2s = 19'(ax * ax) + 19'(ay * ay);

        // stamp distance in whole pixels
        sax = ox_reg[OFF_W-1] ? 5'(-ox_reg) : ox_reg[4:0];
        say = oy_reg[OFF_W-1] ? 5'(-oy_reg) : oy_reg[4:0];
        d2g = 11'(sax * sax) + 11'(say * say);

        // one root bit per cycle
        rem_sh = {sq_rem_reg[SQR_W+1:0], sq_rad_reg[SQI_W-1 -: 2]};
        trial  = {2'b00, sq_root_reg, 2'b01};

        st = 30'(sq_root_reg) * 30'(glow_inv_reg);
        p1 = 34'(r1_reg) * 34'(gsfe_pkg::exp_lo(t_reg[3:0])) + 34'd32768;
        p2 = 34'(gsfe_pkg::exp_int(t_reg[11:8])) * 34'(gsfe_pkg::exp_hi(t_reg[7:4]))
           + 34'd32768;
        pa = 34'(inten_reg) * 34'(e_reg) + 34'd32768;
        sum = 18'(mem_rdata_reg) + 18'(val_reg);

        stamp_r = (5'(stamp_radius_reg) > 5'(MAX_STAMP_RADIUS))
                ? 5'(MAX_STAMP_RADIUS) : 5'(stamp_radius_reg);

        case (state_reg)
            gsfe_pkg::ST_CLEAR: begin
                mem_addr      = clr_addr_reg;
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_addr_next = '0;
                    state_next    = clr_item_reg ? gsfe_pkg::ST_DONE : gsfe_pkg::ST_IDLE;
                end
            end
            gsfe_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = s_tuser;
                    cx_next     = cxw[CTR_W-1:0];
                    cy_next     = cyw[CTR_W-1:0];
                    fx_next     = OFF_W'(px - (cxw <<< 4));
                    fy_next     = OFF_W'(py - (cyw <<< 4));
                    inten_next  = s_tdata[47:32];
                    prod_r_next = '0;
                    prod_g_next = '0;
                    prod_b_next = '0;
                    pv_next     = 1'b0;
                    case (s_tuser)
                        gsfe_pkg::ACT_SPLAT: begin
                            rad_next   = 5'(SPLAT_RADIUS);
                            ox_next    = -$signed(OFF_W'(SPLAT_RADIUS));
                            oy_next    = -$signed(OFF_W'(SPLAT_RADIUS));
                            state_next = gsfe_pkg::ST_PIX;
                        end
                        gsfe_pkg::ACT_STAMP: begin
                            rad_next   = stamp_r;
                            ox_next    = -$signed({1'b0, stamp_r});
                            oy_next    = -$signed({1'b0, stamp_r});
                            state_next = gsfe_pkg::ST_PIX;
                        end
                        gsfe_pkg::ACT_READ: begin
                            rad_next   = '0;
                            ox_next    = '0;
                            oy_next    = '0;
                            state_next = gsfe_pkg::ST_PIX;
                        end
                        default: begin
                            clr_item_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = gsfe_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end
            gsfe_pkg::ST_PIX: begin
                addr_next = AW'(y[CTR_W-1:0]) * AW'(MAX_WIDTH) + AW'(x[CTR_W-1:0]);
                t_next    = T_W'((d2s + 19'd4) >> 3);
                sq_rad_next  = SQI_W'({d2g, 16'd0});
                sq_rem_next  = '0;
                sq_root_next = '0;
                sq_cnt_next  = '0;
                if (!in_frame) begin
                    // pixel off the frame: step on
                    if (last_pix) begin
                        state_next = gsfe_pkg::ST_DONE;
                    end else if (ox_reg == $signed(rad_ext)) begin
                        ox_next = -$signed(rad_ext);
                        oy_next = oy_reg + 1'b1;
                    end else begin
                        ox_next = ox_reg + 1'b1;
                    end
                end else begin
                    case (act_reg)
                        gsfe_pkg::ACT_SPLAT: state_next = gsfe_pkg::ST_EXP1;
                        gsfe_pkg::ACT_STAMP: state_next = gsfe_pkg::ST_SQRT;
                        default:             state_next = gsfe_pkg::ST_PRD;
                    endcase
                end
            end
            gsfe_pkg::ST_SQRT: begin
                sq_rad_next = sq_rad_reg << 2;
                if (rem_sh >= trial) begin
                    sq_rem_next  = rem_sh - trial;
                    sq_root_next = {sq_root_reg[SQR_W-2:0], 1'b1};
                end else begin
                    sq_rem_next  = rem_sh;
                    sq_root_next = {sq_root_reg[SQR_W-2:0], 1'b0};
                end
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 4'(SQR_W - 1)) begin
                    state_next = gsfe_pkg::ST_TSCALE;
                end
            end
            gsfe_pkg::ST_TSCALE: begin
                t_next     = T_W'((st + 30'd128) >> 8);
                state_next = gsfe_pkg::ST_EXP1;
            end
            gsfe_pkg::ST_EXP1: begin
                ezero_next = (t_reg[T_W-1:8] >= 14'd12);
                r1_next    = p2[32:16];
                state_next = gsfe_pkg::ST_EXP2;
            end
            gsfe_pkg::ST_EXP2: begin
                e_next     = ezero_reg ? '0 : p1[32:16];
                state_next = gsfe_pkg::ST_SCALE;
            end
            gsfe_pkg::ST_SCALE: begin
                if (act_reg == gsfe_pkg::ACT_SPLAT) begin
                    val_next   = pa[32:16];
                    state_next = gsfe_pkg::ST_RD;
                end else if (e_reg <= gsfe_pkg::GLOW_MIN_E) begin
                    // glow too faint: leave pixel
                    if (last_pix) begin
                        state_next = gsfe_pkg::ST_DONE;
                    end else begin
                        state_next = gsfe_pkg::ST_PIX;
                        if (ox_reg == $signed(rad_ext)) begin
                            ox_next = -$signed(rad_ext);
                            oy_next = oy_reg + 1'b1;
                        end else begin
                            ox_next = ox_reg + 1'b1;
                        end
                    end
                end else begin
                    val_next   = (e_reg + 17'd8) >> 4;
                    state_next = gsfe_pkg::ST_RD;
                end
            end
            gsfe_pkg::ST_RD: begin
                state_next = gsfe_pkg::ST_WR;
            end
            gsfe_pkg::ST_WR: begin
                if (act_reg == gsfe_pkg::ACT_SPLAT) begin
                    mem_we    = 1'b1;
                    mem_wdata = sum[17:16] != 2'b00 ? 16'hFFFF : sum[15:0];
                end else begin
                    mem_we    = val_reg > 17'(mem_rdata_reg);
                    mem_wdata = val_reg[15:0];
                end
                if (last_pix) begin
                    state_next = gsfe_pkg::ST_DONE;
                end else begin
                    state_next = gsfe_pkg::ST_PIX;
                    if (ox_reg == $signed(rad_ext)) begin
                        ox_next = -$signed(rad_ext);
                        oy_next = oy_reg + 1'b1;
                    end else begin
                        ox_next = ox_reg + 1'b1;
                    end
                end
            end
            gsfe_pkg::ST_PRD: begin
                state_next = gsfe_pkg::ST_COLOR;
            end
            gsfe_pkg::ST_COLOR: begin
                prod_r_next = 28'(color_red_reg) * 28'(mem_rdata_reg);
                prod_g_next = 28'(color_green_reg) * 28'(mem_rdata_reg);
                prod_b_next = 28'(color_blue_reg) * 28'(mem_rdata_reg);
                pv_next     = 1'b1;
                state_next  = gsfe_pkg::ST_DONE;
            end
            gsfe_pkg::ST_DONE: begin
                // wait for a free output register
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {color_byte(prod_b_reg), color_byte(prod_g_reg),
                                     color_byte(prod_r_reg)};
                    m_tuser_next  = pv_reg;
                    clr_item_next = 1'b0;
                    state_next    = gsfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gsfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gsfe_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        inten_reg   <= inten_next;
        rad_reg     <= rad_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        addr_reg    <= addr_next;
        t_reg       <= t_next;
        sq_rad_reg  <= sq_rad_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        sq_cnt_reg  <= sq_cnt_next;
        ezero_reg   <= ezero_next;
        r1_reg      <= r1_next;
        e_reg       <= e_next;
        val_reg     <= val_next;
        prod_r_reg  <= prod_r_next;
        prod_g_reg  <= prod_g_next;
        prod_b_reg  <= prod_b_next;
        pv_reg      <= pv_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // ---------------- checks ----------------
    // an accepted item holds the input closed in the following cycle
    `GSFE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the store is written only by the clearing pass or a pixel write-back
    `GSFE_ASSERT_NOW(a_write_source, aclk, aresetn, mem_we,
        (state_reg == gsfe_pkg::ST_CLEAR) || (state_reg == gsfe_pkg::ST_WR))
    // results that hit no pixel carry black
    `GSFE_ASSERT_NOW(a_black_when_invalid, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata == 24'd0)

endmodule

// ===== tb/gsfe_checker.sv =====
// checker for the glow splat frame engine: tracks the frame store and the registers
// from the bus traffic, predicts each result item and compares it; depends on gsfe_pkg
module gsfe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, splat_intensity
    input  logic [1:0]  s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // red, green, blue
    input  logic        m_tuser,   // pixel_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          outstanding,
    output int          fail_count
);

    localparam int FW = gsfe_pkg::DEF_MAX_WIDTH;
    localparam int FH = gsfe_pkg::DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pixel_valid;
    } pixel_rgb_t;

    localparam longint unsigned DECAY_INT[12] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    localparam longint unsigned DECAY_HI[16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam longint unsigned DECAY_LO[16] = '{
        65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
        63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

    logic [15:0] intensity_map [FW*FH];
    logic [7:0]  cfg_width, cfg_height;
    logic [3:0]  cfg_radius;
    logic [15:0] cfg_glow;
    logic [11:0] cfg_red, cfg_green, cfg_blue;
    pixel_rgb_t  pixel_results_q[$];

    initial begin
        foreach (intensity_map[i]) intensity_map[i] = '0;
        cfg_width  = gsfe_pkg::RST_FRAME_WIDTH;
        cfg_height = gsfe_pkg::RST_FRAME_HEIGHT;
        cfg_radius = gsfe_pkg::RST_STAMP_RADIUS;
        cfg_glow   = gsfe_pkg::RST_GLOW_INV;
        cfg_red    = gsfe_pkg::RST_COLOR;
        cfg_green  = gsfe_pkg::RST_COLOR;
        cfg_blue   = gsfe_pkg::RST_COLOR;
        fail_count = 0;
    end

    assign outstanding = pixel_results_q.size();

    // exp(-t), t in q.8, result q0.16
    function automatic longint unsigned decay_q16(longint unsigned t);
        longint unsigned n, r;
        n = t >> 8;
        if (n >= 12) return 0;
        r = (DECAY_INT[n] * DECAY_HI[(t >> 4) & 15] + 32768) >> 16;
        r = (r * DECAY_LO[t & 15] + 32768) >> 16;
        return r;
    endfunction

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned root, b;
        root = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [7:0] gain_byte(logic [11:0] gain, logic [15:0] pix);
        longint unsigned c;
        c = (longint'(gain) * longint'(pix) * 255) >> 20;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    // applies one item to the frame store and returns its result
    function automatic pixel_rgb_t frame_apply(logic [1:0] act, logic [47:0] d);
        int px, py, cx, cy, w, h, r, x, y;
        int unsigned ax, ay, d2, s, total;
        longint unsigned wt, add, t, e, v;
        logic [15:0] inten;
        pixel_rgb_t res;
        px = $signed(d[15:0]);
        py = $signed(d[31:16]);
        inten = d[47:32];
        cx = px / 16;
        cy = py / 16;
        w = (cfg_width > FW) ? FW : cfg_width;
        h = (cfg_height > FH) ? FH : cfg_height;
        res = '0;
        case (act)
            gsfe_pkg::ACT_SPLAT: begin
                for (y = cy - gsfe_pkg::DEF_SPLAT_RADIUS;
                     y <= cy + gsfe_pkg::DEF_SPLAT_RADIUS; y++) begin
                    if (y < 0 || y >= h) continue;
                    for (x = cx - gsfe_pkg::DEF_SPLAT_RADIUS;
                         x <= cx + gsfe_pkg::DEF_SPLAT_RADIUS; x++) begin
                        if (x < 0 || x >= w) continue;
                        ax = (x*16 - px < 0) ? px - x*16 : x*16 - px;
                        ay = (y*16 - py < 0) ? py - y*16 : y*16 - py;
                        d2 = ax*ax + ay*ay;
                        wt = decay_q16((d2 + 4) >> 3);
                        add = (longint'(inten) * wt + 32768) >> 16;
                        total = intensity_map[y*FW + x] + add;
                        intensity_map[y*FW + x] = (total > 65535) ? 16'hFFFF : total[15:0];
                    end
                end
            end
            gsfe_pkg::ACT_STAMP: begin
                r = (cfg_radius > gsfe_pkg::DEF_MAX_STAMP_RADIUS)
                  ? gsfe_pkg::DEF_MAX_STAMP_RADIUS : cfg_radius;
                for (y = cy - r; y <= cy + r; y++) begin
                    if (y < 0 || y >= h) continue;
                    for (x = cx - r; x <= cx + r; x++) begin
                        if (x < 0 || x >= w) continue;
                        ax = (x < cx) ? cx - x : x - cx;
                        ay = (y < cy) ? cy - y : y - cy;
                        s = floor_sqrt((ax*ax + ay*ay) << 16);
                        t = (longint'(s) * cfg_glow + 128) >> 8;
                        e = decay_q16(t);
                        // glow below 1/255 leaves the pixel alone
                        if (e * 255 < 65536) continue;
                        v = (e + 8) >> 4;
                        if (v > intensity_map[y*FW + x]) intensity_map[y*FW + x] = v[15:0];
                    end
                end
            end
            gsfe_pkg::ACT_READ: begin
                if (cx >= 0 && cx < w && cy >= 0 && cy < h) begin
                    res.red   = gain_byte(cfg_red,   intensity_map[cy*FW + cx]);
                    res.green = gain_byte(cfg_green, intensity_map[cy*FW + cx]);
                    res.blue  = gain_byte(cfg_blue,  intensity_map[cy*FW + cx]);
                    res.pixel_valid = 1'b1;
                end
            end
            default: begin
                foreach (intensity_map[i]) intensity_map[i] = '0;
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        pixel_rgb_t want, got;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    gsfe_pkg::REG_FRAME_WIDTH:  cfg_width  = pwdata[7:0];
                    gsfe_pkg::REG_FRAME_HEIGHT: cfg_height = pwdata[7:0];
                    gsfe_pkg::REG_STAMP_RADIUS: cfg_radius = pwdata[3:0];
                    gsfe_pkg::REG_GLOW_INV:     cfg_glow   = pwdata[15:0];
                    gsfe_pkg::REG_COLOR_RED:    cfg_red    = pwdata[11:0];
                    gsfe_pkg::REG_COLOR_GREEN:  cfg_green  = pwdata[11:0];
                    gsfe_pkg::REG_COLOR_BLUE:   cfg_blue   = pwdata[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) pixel_results_q.push_back(frame_apply(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser};
                if (pixel_results_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    want = pixel_results_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("red expected %0d actual %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green expected %0d actual %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue expected %0d actual %0d", want.blue, got.blue);
                        fail_count++;
                    end
                    if (got.pixel_valid !== want.pixel_valid) begin
                        $error("pixel_valid expected %0d actual %0d",
                               want.pixel_valid, got.pixel_valid);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the glow splat frame engine: clock, reset, register writes and
// item traffic with random gaps; depends on gsfe_pkg, gsfe_checker and the engine
module tb;

    // generous ceiling: reset clear, worst stamps and splats, every gap and stall
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // pos_x, pos_y, splat_intensity
    logic [1:0]  s_tuser = gsfe_pkg::ACT_READ;   // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // red, green, blue
    logic        m_tuser;   // pixel_valid
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int     outstanding, fail_count;
    longint cycles = 0;
    int     act_count[4];
    int     results_taken = 0;
    bit     send_gaps = 1'b1, take_gaps = 1'b1;

    glow_splat_frame_engine dut (.*);

    gsfe_checker chk (.*);

    // clock, period 12
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run ceiling
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("glow_splat_frame_engine verification failed");
            $finish;
        end
    end

    // one register write: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int r, int glow, int cr, int cg, int cb);
        reg_write(gsfe_pkg::REG_FRAME_WIDTH, w);
        reg_write(gsfe_pkg::REG_FRAME_HEIGHT, h);
        reg_write(gsfe_pkg::REG_STAMP_RADIUS, r);
        reg_write(gsfe_pkg::REG_GLOW_INV, glow);
        reg_write(gsfe_pkg::REG_COLOR_RED, cr);
        reg_write(gsfe_pkg::REG_COLOR_GREEN, cg);
        reg_write(gsfe_pkg::REG_COLOR_BLUE, cb);
        @(posedge aclk);
    endtask

    // offer one item, hold it until taken; valid stays high across back-to-back items
    task automatic send_item(logic [1:0] act, logic [15:0] x, logic [15:0] y,
                             logic [15:0] inten);
        int gap;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {inten, y, x};
        do @(posedge aclk); while (!s_tready);
        act_count[act]++;
    endtask

    // coordinate in q12.4: mostly near the frame, sometimes any 16-bit value
    function automatic logic [15:0] rand_coord();
        if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 2400)) - 200);
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] rand_action(bit wide_stamp);
        int p;
        p = $urandom_range(0, 99);
        if (p == 0) return gsfe_pkg::ACT_CLEAR;
        if (p < 31) return gsfe_pkg::ACT_SPLAT;
        // wide stamp windows are slow, keep them rare
        if (p < (wide_stamp ? 33 : 43)) return gsfe_pkg::ACT_STAMP;
        return gsfe_pkg::ACT_READ;
    endfunction

    // result side: random stalls, one long hold to back the engine up
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (results_taken == 400) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end
            gap = take_gaps ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_taken++;
            if (results_taken % 60 == 0) take_gaps = $urandom_range(0, 2) != 0;
        end
    end

    initial begin
        int rad;
        bit wide;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every action, edges and saturation
        send_item(gsfe_pkg::ACT_READ,  16'd0, 16'd0, 16'd0);
        send_item(gsfe_pkg::ACT_SPLAT, 16'd0, 16'd0, 16'hFFFF);
        send_item(gsfe_pkg::ACT_SPLAT, 16'd8, 16'd8, 16'hFFFF);
        send_item(gsfe_pkg::ACT_SPLAT, 16'd4, 16'd12, 16'hFFFF);
        send_item(gsfe_pkg::ACT_READ,  16'd0, 16'd0, 16'hFFFF);
        send_item(gsfe_pkg::ACT_SPLAT, -16'sd15, -16'sd15, 16'd4096);   // truncates to pixel 0
        send_item(gsfe_pkg::ACT_SPLAT, 16'd1599, 16'd1599, 16'h8000);   // last in-frame pixel
        send_item(gsfe_pkg::ACT_READ,  16'd1599, 16'd1599, 16'd0);
        send_item(gsfe_pkg::ACT_READ,  16'd1600, 16'd0, 16'd0);         // just past the width
        send_item(gsfe_pkg::ACT_READ,  16'd0, 16'd1600, 16'd0);
        send_item(gsfe_pkg::ACT_READ,  -16'sd16, 16'd0, 16'd0);
        send_item(gsfe_pkg::ACT_READ,  16'h7FFF, 16'h8000, 16'd0);
        send_item(gsfe_pkg::ACT_SPLAT, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(gsfe_pkg::ACT_STAMP, 16'd800, 16'd800, 16'd0);
        send_item(gsfe_pkg::ACT_READ,  16'd800, 16'd800, 16'd0);
        send_item(gsfe_pkg::ACT_READ,  16'd864, 16'd800, 16'd0);
        send_item(gsfe_pkg::ACT_STAMP, 16'd0, 16'd0, 16'hFFFF);   // window clipped at the corner
        send_item(gsfe_pkg::ACT_READ,  16'd16, 16'd0, 16'd0);
        send_item(gsfe_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(gsfe_pkg::ACT_READ,  16'd800, 16'd800, 16'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                // registers change only with the engine idle
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
                case (ph)
                    1: set_frame(255, 255, 15, 65535, 4095, 0, 4095);
                    2: set_frame(0, 0, 0, 0, 0, 4095, 0);
                    3: set_frame(1, 1, 1, 0, 4095, 4095, 4095);
                    4: set_frame(128, 128, 3, 200, $urandom_range(0, 4095),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095));
                    default: set_frame($urandom_range(1, 255), $urandom_range(1, 255),
                                       $urandom_range(0, 6), $urandom_range(0, 65535),
                                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                                       $urandom_range(0, 4095));
                endcase
            end
            rad  = (ph == 0) ? 7 : (ph == 1) ? 15 : 6;
            wide = rad > 6;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) send_gaps = $urandom_range(0, 2) != 0;
                send_item(rand_action(wide), rand_coord(), rand_coord(), 16'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // drain, then let the engine settle
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d splats, %0d stamps, %0d reads, %0d clears over %0d settings",
                 act_count[gsfe_pkg::ACT_SPLAT], act_count[gsfe_pkg::ACT_STAMP],
                 act_count[gsfe_pkg::ACT_READ], act_count[gsfe_pkg::ACT_CLEAR], PHASES);
        if (fail_count == 0) begin
            $display("glow_splat_frame_engine verification clean");
        end else begin
            $display("glow_splat_frame_engine verification failed");
        end
        $finish;
    end

endmodule

// ===== glow_splat_frame_engine.f =====
+incdir+sv
sv/gsfe_pkg.sv
sv/glow_splat_frame_engine.sv
tb/gsfe_checker.sv
tb/tb.sv
